@@ rtl/pcgrig_pkg.sv @@
// Shared types, constants and the XSH RR output function for the PCG32
// ranged integer generator. No dependencies.
package pcgrig_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned STATE_W = 64;
    localparam int unsigned RANGE_W = WORD_W + 1;   // range width 1..2^32
    localparam int unsigned CNT_W   = $clog2(WORD_W);

    // register index (paddr[3]), 64-bit registers on an 8-byte pitch
    localparam logic ADDR_START_STATE = 1'b0;
    localparam logic ADDR_STREAM_INC  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic load;     // load running state from start_state
        logic start;    // advance state once
    } lcg_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, remainder valid from here on
    } mod_stat_t;

    // XSH RR: xorshift high bits down, then rotate right by the top five bits
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0]  mix;
        logic [WORD_W-1:0]   word;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        mix  = old ^ (old >> 18);
        word = mix[58:27];
        rot  = old[63:59];
        dbl  = {word, word} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/pcgrig_lcg.sv @@
// 64-bit LCG state with a shared 32x32 multiplier that forms the partial products in turn.
// Depends on pcgrig_pkg.
module pcgrig_lcg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pcgrig_pkg::lcg_cmd_t           cmd,
    input  logic [pcgrig_pkg::STATE_W-1:0] load_value,
    input  logic [pcgrig_pkg::STATE_W-1:0] increment,
    output logic [pcgrig_pkg::STATE_W-1:0] state
);

    logic [63:0] state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // low 64 bits of state * mult = lo*lo + ((hi*lo + lo*hi) << 32)
    always_comb begin
        case (step_reg)
            2'd1: begin
                mul_a = state_reg[63:32];
                mul_b = pcgrig_pkg::PCG_MULT[31:0];
            end
            2'd2: begin
                mul_a = state_reg[31:0];
                mul_b = pcgrig_pkg::PCG_MULT[63:32];
            end
            default: begin
                mul_a = state_reg[31:0];
                mul_b = pcgrig_pkg::PCG_MULT[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        if (cmd.load) begin
            state_next = load_value;
        end else if (cmd.start) begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 2'd1;
            case (step_reg)
                2'd0: acc_next = prod;
                2'd1, 2'd2: acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                default: begin
                    state_next = acc_reg + {increment[63:1], 1'b1};
                    busy_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
        end
        acc_reg <= acc_next;
    end

    assign state = state_reg;

endmodule

@@ rtl/pcgrig_mod.sv @@
// Restoring remainder unit: 32-bit word mod 33-bit width, one bit per cycle.
// Depends on pcgrig_pkg.
module pcgrig_mod (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pcgrig_pkg::WORD_W-1:0]  dividend,
    input  logic [pcgrig_pkg::RANGE_W-1:0] divisor,
    output logic [pcgrig_pkg::WORD_W-1:0]  remainder,
    output pcgrig_pkg::mod_stat_t          stat
);

    localparam int unsigned W = pcgrig_pkg::WORD_W;

    logic [W:0]                      rem_reg, rem_next;
    logic [W-1:0]                    dvd_reg, dvd_next;
    logic [W:0]                      dvs_reg;
    logic [pcgrig_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [W:0]                      trial;

    // remainder stays below the divisor (at most 2^32), so bit W is free
    assign trial = {rem_reg[W-1:0], dvd_reg[W-1]};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = pcgrig_pkg::CNT_W'(W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = (trial >= dvs_reg) ? trial - dvs_reg : trial;
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign remainder = rem_reg[W-1:0];
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

@@ rtl/pcg32_ranged_integer_generator.sv @@
// Top level of the PCG32 ranged integer generator: stream channels, APB
// registers and the control sequencer. Depends on pcgrig_pkg, pcgrig_lcg, pcgrig_mod.
//
// Use: each input beat carries an inclusive range (range_low, range_high).
// The block steps its 64-bit PCG state once, returns the XSH RR word of the
// old state as raw_word, and range_low + raw_word mod (high - low + 1) as
// ranged_value. When range_high < range_low (as signed values), range_error is set and
// ranged_value is range_low; the state still advances.
// The result beat is registered in the output register once the remainder
// unit finishes. Input beats are taken one at a time, paced by the remainder
// unit, which retires one quotient bit per cycle; the state update runs
// alongside it on a shared 32x32 multiplier.
// s_tready is high only while no beat is in work; one finished result may
// wait in the output register while the next beat is taken.
// If the receiver stalls, the finished result waits inside the block and
// no new beat is taken until the output register frees.
// Reset clears the state, both registers and the output valid flag; the output data is not reset.
// Registers: start_state at 0x0 (write loads the state), stream_increment
// at 0x8. Write configuration only while idle.
module pcg32_ranged_integer_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] range_low, [63:32] range_high
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] raw_word, [63:32] ranged_value
    output logic        m_tuser,    // [0] range_error
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    pcgrig_pkg::ctl_state_t state_reg, state_next;

    logic [63:0] start_state_reg;
    logic [63:0] stream_inc_reg;
    logic        cfg_wr;
    logic        accept;
    logic        out_free;
    logic        out_load;

    logic [31:0] low_reg;
    logic [31:0] word_reg;
    logic        err_reg;

    logic [31:0] m_word_reg, m_ranged_reg;
    logic        m_err_reg;
    logic        m_tvalid_reg, m_tvalid_next;

    logic [63:0]           lcg_state;
    pcgrig_pkg::lcg_cmd_t  lcg_cmd;
    logic [31:0]           rem;
    pcgrig_pkg::mod_stat_t mod_stat;

    logic signed [33:0] diff;
    logic [32:0]        range_width;

    // APB: register index is paddr[3], low address bits ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == pcgrig_pkg::ADDR_STREAM_INC) ? stream_inc_reg
                                                               : start_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_state_reg <= '0;
            stream_inc_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr[3] == pcgrig_pkg::ADDR_START_STATE) begin
                start_state_reg <= pwdata;
            end else begin
                stream_inc_reg <= pwdata;
            end
        end
    end

    // range width in 33 bits; negative difference flags an inverted range
    assign diff        = 34'(signed'(s_tdata[63:32])) - 34'(signed'(s_tdata[31:0]));
    assign range_width = diff[32:0] + 33'd1;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign lcg_cmd = '{load: cfg_wr && (paddr[3] == pcgrig_pkg::ADDR_START_STATE),
                       start: accept};

    pcgrig_lcg u_lcg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (lcg_cmd),
        .load_value (pwdata),
        .increment  (stream_inc_reg),
        .state      (lcg_state)
    );

    pcgrig_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (pcgrig_pkg::xsh_rr(lcg_state)),
        .divisor   (range_width),
        .remainder (rem),
        .stat      (mod_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcgrig_pkg::ST_IDLE: begin
                if (accept) state_next = pcgrig_pkg::ST_RUN;
            end
            pcgrig_pkg::ST_RUN: begin
                if (mod_stat.done) begin
                    state_next = out_free ? pcgrig_pkg::ST_IDLE : pcgrig_pkg::ST_HOLD;
                end
            end
            pcgrig_pkg::ST_HOLD: begin
                if (out_free) state_next = pcgrig_pkg::ST_IDLE;
            end
            default: state_next = pcgrig_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            pcgrig_pkg::ST_IDLE: s_tready = 1'b1;
            pcgrig_pkg::ST_RUN:  out_load = mod_stat.done && out_free;
            pcgrig_pkg::ST_HOLD: out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcgrig_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept) begin
            low_reg  <= s_tdata[31:0];
            word_reg <= pcgrig_pkg::xsh_rr(lcg_state);
            err_reg  <= diff[33];
        end
        if (out_load) begin
            m_word_reg   <= word_reg;
            m_ranged_reg <= err_reg ? low_reg : low_reg + rem;
            m_err_reg    <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_ranged_reg, m_word_reg};
    assign m_tuser  = m_err_reg;

endmodule

@@ rtl/pcgrig_chk.sv @@
// Port-level checker for the PCG32 ranged integer generator, bound to the top.
// Depends only on the top level's ports.
module pcgrig_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // a taken beat closes the input; only the start of the remainder pass is checked
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened while a beat is in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a result follows a beat only after the full pass; only its start is checked
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

endmodule

bind pcg32_ranged_integer_generator pcgrig_chk u_pcgrig_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
